/* hdl/typed_operand_stack_defines.svh */
//----------------------------------------------------------------------------
// typed_operand_stack_defines
// assertion macros used by the checker file of the operand stack
//----------------------------------------------------------------------------
`ifndef TYPED_OPERAND_STACK_DEFINES_SVH
`define TYPED_OPERAND_STACK_DEFINES_SVH

// same-cycle implication, reset masks the check
`define TOS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define TOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tos_pkg.sv */
//----------------------------------------------------------------------------
// tos_pkg
// types, codes and widths shared by the typed operand stack modules
//----------------------------------------------------------------------------
package tos_pkg;

  // fixed field widths of the request and response
  localparam int CMD_W   = 3;
  localparam int POS_W   = 11;
  localparam int TAG_W   = 4;
  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 11;

  // default sizing
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int WORD_WIDTH_DEF  = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RD_REL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WR_REL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RD_ABS = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WR_ABS = 3'd5;

  // status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_EMPTY    = 2'd1;
  localparam logic [1:0] STS_FULL     = 2'd2;
  localparam logic [1:0] STS_UNMAPPED = 2'd3;

  // tag of an empty entry
  localparam logic signed [TAG_W-1:0] TAG_EMPTY = -4'sd1;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [TAG_W-1:0]  type_in;
    logic signed [DATA_W-1:0] data_in;
  } in_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [TAG_W-1:0]  type_out;
    logic signed [DATA_W-1:0] data_out;
    logic [DEPTH_W-1:0]       depth_now;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

endpackage

/* hdl/tos_ctrl.sv */
//----------------------------------------------------------------------------
// tos_ctrl
// sequencer of the operand stack: tag clearing pass, request load,
// execute and response hand-off
//----------------------------------------------------------------------------
module tos_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  tos_pkg::dp_status_t    dp_sts,
  output tos_pkg::ctrl_cmd_t     dp_cmd
);

  tos_pkg::state_t state_r;
  tos_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tos_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tos_pkg::ST_CLEAR: begin
        if (dp_sts.clear_done) state_nxt = tos_pkg::ST_IDLE;
      end
      tos_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tos_pkg::ST_EXEC;
      end
      tos_pkg::ST_EXEC: begin
        state_nxt = tos_pkg::ST_RESP;
      end
      tos_pkg::ST_RESP: begin
        if (!out_stall) state_nxt = tos_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tos_pkg::ST_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    dp_cmd    = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      tos_pkg::ST_CLEAR: begin
        dp_cmd.clear = 1'b1;
      end
      tos_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        dp_cmd.load = in_valid;
      end
      tos_pkg::ST_EXEC: begin
        dp_cmd.exec = 1'b1;
      end
      tos_pkg::ST_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* hdl/tos_dp.sv */
//----------------------------------------------------------------------------
// tos_dp
// datapath of the operand stack: request register, stack top, tag and
// word memories, bounds checks and response registers
//----------------------------------------------------------------------------
module tos_dp #(
  parameter int STACK_DEPTH = tos_pkg::STACK_DEPTH_DEF,
  parameter int WORD_WIDTH  = tos_pkg::WORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tos_pkg::ctrl_cmd_t  dp_cmd,
  output tos_pkg::dp_status_t dp_sts,
  input  tos_pkg::in_req_t    in_req,
  output tos_pkg::out_rsp_t   out_rsp
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (TW > tos_pkg::POS_W) ? TW : tos_pkg::POS_W;
  localparam int XW = (WORD_WIDTH > tos_pkg::DATA_W) ? WORD_WIDTH : tos_pkg::DATA_W;

  // request and control state
  tos_pkg::in_req_t      req_r;
  logic [TW-1:0]         top_r;
  logic [TW-1:0]         top_nxt;
  logic [AW-1:0]         clr_idx_r;
  logic [1:0]            status_r;
  logic [1:0]            status_nxt;
  logic                  has_val_r;
  logic                  has_val_nxt;

  // memories and read data
  logic [tos_pkg::TAG_W-1:0] tag_mem [STACK_DEPTH];
  logic [WORD_WIDTH-1:0]     word_mem [STACK_DEPTH];
  logic [tos_pkg::TAG_W-1:0] tag_rd_r;
  logic [WORD_WIDTH-1:0]     word_rd_r;

  // access decode
  logic [AW-1:0]             idx;
  logic                      tag_we;
  logic                      word_we;
  logic [tos_pkg::TAG_W-1:0] tag_wd;
  logic [WORD_WIDTH-1:0]     word_wd;
  logic [CW-1:0]             pos_ext;
  logic [CW-1:0]             top_ext;
  logic [CW-1:0]             rel_diff;
  logic [TW-1:0]             top_m1;
  logic                      rel_ok;
  logic                      abs_ok;
  logic                      full;

  // response shaping
  logic signed [WORD_WIDTH-1:0] word_s;
  logic signed [XW-1:0]         word_x;

  // request capture
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      req_r <= in_req;
    end
  end

  // bounds and entry index
  assign pos_ext  = CW'(req_r.position);
  assign top_ext  = CW'(top_r);
  assign rel_diff = top_ext - pos_ext - CW'(1);
  assign top_m1   = top_r - TW'(1);
  assign rel_ok   = pos_ext < top_ext;
  assign abs_ok   = pos_ext < CW'(STACK_DEPTH);
  assign full     = top_r >= TW'(STACK_DEPTH);
  assign word_wd  = WORD_WIDTH'($unsigned(req_r.data_in));

  // command decode
  always_comb begin
    idx         = top_r[AW-1:0];
    tag_we      = 1'b0;
    word_we     = 1'b0;
    tag_wd      = req_r.type_in;
    top_nxt     = top_r;
    status_nxt  = tos_pkg::STS_OK;
    has_val_nxt = 1'b0;
    case (req_r.command)
      tos_pkg::CMD_PUSH: begin
        if (full) begin
          status_nxt = tos_pkg::STS_FULL;
        end else begin
          tag_we  = 1'b1;
          word_we = 1'b1;
          top_nxt = top_r + TW'(1);
        end
      end
      tos_pkg::CMD_POP: begin
        if (top_r == '0) begin
          status_nxt = tos_pkg::STS_EMPTY;
        end else begin
          idx         = top_m1[AW-1:0];
          top_nxt     = top_m1;
          has_val_nxt = 1'b1;
          tag_we      = 1'b1;
          tag_wd      = tos_pkg::TAG_EMPTY;
        end
      end
      tos_pkg::CMD_RD_REL, tos_pkg::CMD_WR_REL: begin
        idx = rel_diff[AW-1:0];
        if (!rel_ok) begin
          status_nxt = tos_pkg::STS_UNMAPPED;
        end else if (req_r.command == tos_pkg::CMD_WR_REL) begin
          tag_we  = 1'b1;
          word_we = 1'b1;
        end else begin
          has_val_nxt = 1'b1;
        end
      end
      tos_pkg::CMD_RD_ABS, tos_pkg::CMD_WR_ABS: begin
        idx = pos_ext[AW-1:0];
        if (!abs_ok) begin
          status_nxt = tos_pkg::STS_UNMAPPED;
        end else if (req_r.command == tos_pkg::CMD_WR_ABS) begin
          tag_we  = 1'b1;
          word_we = 1'b1;
        end else begin
          has_val_nxt = 1'b1;
        end
      end
      default: begin
        status_nxt = tos_pkg::STS_OK;
      end
    endcase
  end

  // tag memory, swept to empty after reset
  always_ff @(posedge clk) begin
    if (dp_cmd.clear) begin
      tag_mem[clr_idx_r] <= tos_pkg::TAG_EMPTY;
    end else if (dp_cmd.exec && tag_we) begin
      tag_mem[idx] <= tag_wd;
    end
    if (dp_cmd.exec) begin
      tag_rd_r <= tag_mem[idx];
    end
  end

  // word memory
  always_ff @(posedge clk) begin
    if (dp_cmd.exec && word_we) begin
      word_mem[idx] <= word_wd;
    end
    if (dp_cmd.exec) begin
      word_rd_r <= word_mem[idx];
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (dp_cmd.clear) begin
      clr_idx_r <= clr_idx_r + AW'(1);
    end
  end

  assign dp_sts.clear_done = dp_cmd.clear && (clr_idx_r == AW'(STACK_DEPTH - 1));

  // stack top and response status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r     <= '0;
      status_r  <= tos_pkg::STS_OK;
      has_val_r <= 1'b0;
    end else if (dp_cmd.exec) begin
      top_r     <= top_nxt;
      status_r  <= status_nxt;
      has_val_r <= has_val_nxt;
    end
  end

  // response: word sign-extended from its stored width
  assign word_s = word_rd_r;
  assign word_x = XW'(word_s);

  assign out_rsp.status    = status_r;
  assign out_rsp.type_out  = has_val_r ? tag_rd_r : tos_pkg::TAG_EMPTY;
  assign out_rsp.data_out  = has_val_r ? word_x[tos_pkg::DATA_W-1:0] : '0;
  assign out_rsp.depth_now = tos_pkg::DEPTH_W'(top_r);

endmodule

/* hdl/typed_operand_stack.sv */
//----------------------------------------------------------------------------
// typed_operand_stack
// operand stack with typed entries, push/pop and relative or absolute
// random access, one response per request
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_req  (command, position, tag, word)
//   out     | output    | out_valid/out_stall| out_rsp (status, tag, word, depth)
//
// a request runs through load, execute (one memory port access) and response
// the response holds while out_stall is high; no request is taken until it leaves
// after reset a tag clearing pass sweeps all STACK_DEPTH entries (1024 by default),
// with in_stall high throughout
//----------------------------------------------------------------------------
module typed_operand_stack #(
  parameter int STACK_DEPTH = tos_pkg::STACK_DEPTH_DEF,
  parameter int WORD_WIDTH  = tos_pkg::WORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tos_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output tos_pkg::out_rsp_t out_rsp
);

  tos_pkg::ctrl_cmd_t  dp_cmd;
  tos_pkg::dp_status_t dp_sts;

  // sequencer
  tos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_sts    (dp_sts),
    .dp_cmd    (dp_cmd)
  );

  // storage and datapath
  tos_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .dp_cmd  (dp_cmd),
    .dp_sts  (dp_sts),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

endmodule

/* hdl/tos_checker.sv */
//----------------------------------------------------------------------------
// tos_checker
// port-level checks of the operand stack, bound to the top level
//----------------------------------------------------------------------------
`include "typed_operand_stack_defines.svh"

module tos_checker #(
  parameter int STACK_DEPTH = tos_pkg::STACK_DEPTH_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tos_pkg::out_rsp_t out_rsp
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a stalled response keeps its payload
  `TOS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_rsp), "stalled response changed")

  // one request in flight: accepting stalls the next cycle
  `TOS_ASSERT_NEXT(a_one_inflight, clk, rst_n, in_acc, in_stall, "request taken while busy")

  // no request accepted while a response waits
  `TOS_ASSERT_NOW(a_rsp_blocks, clk, rst_n, out_valid, in_stall,
    "request open with pending response")

  // a refused command returns no value
  `TOS_ASSERT_NOW(a_refused_empty, clk, rst_n,
    out_valid && (out_rsp.status != tos_pkg::STS_OK),
    (out_rsp.type_out == tos_pkg::TAG_EMPTY) && (out_rsp.data_out == '0),
    "refused command returned a value")

  // full status only with the stack at capacity
  `TOS_ASSERT_NOW(a_full_depth, clk, rst_n,
    out_valid && (out_rsp.status == tos_pkg::STS_FULL),
    out_rsp.depth_now == tos_pkg::DEPTH_W'(STACK_DEPTH),
    "full status below capacity")

endmodule

bind typed_operand_stack tos_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_tos_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);
